// ===== rtl/skt_pkg.sv =====
// Shared types and constants for the sorted key table.
// Used by skt_ctrl, skt_datapath and sorted_key_table_top; depends on nothing.
package skt_pkg;

  localparam int FUNC_W      = 2;
  localparam int KEY_IN_W    = 32;
  localparam int POS_W       = 6;
  localparam int STATUS_W    = 3;
  localparam int INDEX_W     = 6;
  localparam int COUNT_OUT_W = 7;

  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_NULL   = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_BADPOS = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS,
    S_DEL,
    S_SRCH,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INS_START,
    OP_INS_STEP,
    OP_DEL_START,
    OP_DEL_STEP,
    OP_SRCH_START,
    OP_SRCH_STEP,
    OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    set_res;
    status_t res_status;
    logic    res_found;
  } skt_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              key_zero;
    logic              empty;
    logic              pos_bad;
    logic              ins_place;
    logic              del_done;
    logic              srch_end;
    logic              srch_hit;
  } skt_stat_t;

endpackage

// ===== rtl/skt_ctrl.sv =====
// Controller state machine of the sorted key table.
// Depends on skt_pkg; drives skt_datapath through skt_cmd_t and reads skt_stat_t.
module skt_ctrl import skt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  skt_stat_t stat,
  output skt_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    cmd.op         = OP_NONE;
    cmd.set_res    = 1'b0;
    cmd.res_status = ST_OK;
    cmd.res_found  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.func)
          FN_INSERT: begin
            priority if (stat.full) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_FULL;
              state_nxt      = S_DONE;
            end else if (stat.key_zero) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_NULL;
              state_nxt      = S_DONE;
            end else begin
              cmd.op    = OP_INS_START;
              state_nxt = S_INS;
            end
          end
          FN_DELETE: begin
            priority if (stat.empty) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_EMPTY;
              state_nxt      = S_DONE;
            end else if (stat.pos_bad) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_BADPOS;
              state_nxt      = S_DONE;
            end else begin
              cmd.op    = OP_DEL_START;
              state_nxt = S_DEL;
            end
          end
          FN_SEARCH: begin
            cmd.op    = OP_SRCH_START;
            state_nxt = S_SRCH;
          end
          default: begin
            cmd.set_res = 1'b1;
            state_nxt   = S_DONE;
          end
        endcase
      end
      S_INS: begin
        cmd.op = OP_INS_STEP;
        if (stat.ins_place) begin
          cmd.set_res = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_DEL: begin
        if (stat.del_done) begin
          cmd.set_res = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.op = OP_DEL_STEP;
        end
      end
      S_SRCH: begin
        priority if (stat.srch_end) begin
          cmd.set_res = 1'b1;
          state_nxt   = S_DONE;
        end else if (stat.srch_hit) begin
          cmd.set_res   = 1'b1;
          cmd.res_found = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.op = OP_SRCH_STEP;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/skt_datapath.sv =====
// Datapath of the sorted key table: key memory, entry count, search bounds and result registers.
// Depends on skt_pkg; commanded by skt_ctrl.
module skt_datapath import skt_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [FUNC_W-1:0]      in_func,
  input  logic [KEY_IN_W-1:0]    in_key,
  input  logic [POS_W-1:0]       in_position,
  input  skt_cmd_t               cmd,
  output skt_stat_t              stat,
  output logic [STATUS_W-1:0]    out_status,
  output logic                   out_found,
  output logic [INDEX_W-1:0]     out_index,
  output logic [COUNT_OUT_W-1:0] out_count
);

  localparam int KW = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [KW-1:0] mem [DEPTH];

  logic [CW-1:0]          count_r, count_nxt;
  logic [FUNC_W-1:0]      func_r, func_nxt;
  logic [KW-1:0]          key_r, key_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [AW-1:0]          ptr_r, ptr_nxt;
  logic [CW-1:0]          lo_r, lo_nxt;
  logic [CW-1:0]          hi1_r, hi1_nxt;
  logic [AW-1:0]          mid_r, mid_nxt;
  logic [KW-1:0]          rdata_r;
  status_t                res_status_r, res_status_nxt;
  logic                   res_found_r, res_found_nxt;
  logic [INDEX_W-1:0]     res_index_r, res_index_nxt;
  logic [STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic                   out_found_r, out_found_nxt;
  logic [INDEX_W-1:0]     out_index_r, out_index_nxt;
  logic [COUNT_OUT_W-1:0] out_count_r, out_count_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [KW-1:0] mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;

  logic [XW-1:0] count_x, pos_x, ptr_x;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] lo_step, hi1_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    key_r        <= key_nxt;
    pos_r        <= pos_nxt;
    ptr_r        <= ptr_nxt;
    lo_r         <= lo_nxt;
    hi1_r        <= hi1_nxt;
    mid_r        <= mid_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_index_r  <= res_index_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_index_r  <= out_index_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

  assign count_x = XW'(count_r);
  assign pos_x   = XW'(pos_r);
  assign ptr_x   = XW'(ptr_r);

  assign stat.func      = func_r;
  assign stat.full      = (count_x >= XW'(DEPTH));
  assign stat.key_zero  = (key_r == '0);
  assign stat.empty     = (count_r == '0);
  assign stat.pos_bad   = (pos_x >= count_x);
  assign stat.ins_place = (ptr_r == '0) || !(key_r < rdata_r);
  assign stat.del_done  = !(ptr_x < count_x);
  assign stat.srch_end  = !(lo_r < hi1_r);
  assign stat.srch_hit  = (key_r == rdata_r);

  // One halving step of the binary search: narrow the bounds around the probe.
  always_comb begin
    if (key_r < rdata_r) begin
      lo_step  = lo_r;
      hi1_step = CW'(mid_r);
    end else begin
      lo_step  = CW'(mid_r) + CW'(1);
      hi1_step = hi1_r;
    end
    mid_sum = (CW + 1)'(lo_step) + (CW + 1)'(hi1_step) - (CW + 1)'(1);
  end

  always_comb begin
    count_nxt      = count_r;
    func_nxt       = func_r;
    key_nxt        = key_r;
    pos_nxt        = pos_r;
    ptr_nxt        = ptr_r;
    lo_nxt         = lo_r;
    hi1_nxt        = hi1_r;
    mid_nxt        = mid_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_index_nxt  = out_index_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_wa         = ptr_r;
    mem_wd         = rdata_r;
    mem_re         = 1'b0;
    mem_ra         = mid_r;
    unique case (cmd.op)
      OP_LOAD: begin
        func_nxt = in_func;
        key_nxt  = in_key[KW-1:0];
        pos_nxt  = in_position;
      end
      OP_INS_START: begin
        ptr_nxt   = AW'(count_r);
        count_nxt = count_r + CW'(1);
        if (count_r != '0) begin
          mem_re = 1'b1;
          mem_ra = AW'(count_r - CW'(1));
        end
      end
      OP_INS_STEP: begin
        mem_we = 1'b1;
        if (stat.ins_place) begin
          mem_wd = key_r;
        end else begin
          mem_wd  = rdata_r;
          ptr_nxt = ptr_r - AW'(1);
          if (ptr_x >= XW'(2)) begin
            mem_re = 1'b1;
            mem_ra = AW'(ptr_x - XW'(2));
          end
        end
      end
      OP_DEL_START: begin
        ptr_nxt   = AW'(pos_r);
        count_nxt = count_r - CW'(1);
        if ((pos_x + XW'(1)) < count_x) begin
          mem_re = 1'b1;
          mem_ra = AW'(pos_x + XW'(1));
        end
      end
      OP_DEL_STEP: begin
        mem_we  = 1'b1;
        mem_wd  = rdata_r;
        ptr_nxt = AW'(ptr_x + XW'(1));
        if ((ptr_x + XW'(2)) <= count_x) begin
          mem_re = 1'b1;
          mem_ra = AW'(ptr_x + XW'(2));
        end
      end
      OP_SRCH_START: begin
        lo_nxt  = '0;
        hi1_nxt = count_r;
        mid_nxt = AW'((count_r - CW'(1)) >> 1);
        mem_re  = (count_r != '0);
        mem_ra  = AW'((count_r - CW'(1)) >> 1);
      end
      OP_SRCH_STEP: begin
        lo_nxt  = lo_step;
        hi1_nxt = hi1_step;
        mid_nxt = AW'(mid_sum >> 1);
        mem_re  = (lo_step < hi1_step);
        mem_ra  = AW'(mid_sum >> 1);
      end
      OP_PUBLISH: begin
        out_status_nxt = res_status_r;
        out_found_nxt  = res_found_r;
        out_index_nxt  = res_index_r;
        out_count_nxt  = COUNT_OUT_W'(count_r);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_index_nxt  = res_index_r;
    if (cmd.set_res) begin
      res_status_nxt = cmd.res_status;
      res_found_nxt  = cmd.res_found;
      res_index_nxt  = cmd.res_found ? INDEX_W'(mid_r) : '0;
    end
  end

  assign out_status = out_status_r;
  assign out_found  = out_found_r;
  assign out_index  = out_index_r;
  assign out_count  = out_count_r;

endmodule

// ===== rtl/sorted_key_table_top.sv =====
// The sorted key table keeps up to DEPTH unsigned keys in ascending order, duplicates allowed.
// Each request (insert, delete at a position, or binary search) returns one result carrying
// a status, the search outcome and the entry count after the request. The keys live in a
// memory with one write and one registered read per cycle. An insert shifts each entry above
// the new key up by one place, and a delete shifts each entry after the position down by one.
// A search probes the middle of the remaining bounds, with at most log2(count) + 1 probes.
// Rejected requests and the unused function code go straight to the result. The next
// request is taken while a result still waits; its own result then holds until the waiting
// one is taken.
// Depends on skt_pkg, skt_ctrl and skt_datapath.
module sorted_key_table_top import skt_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [FUNC_W-1:0]      in_func,
  input  logic [KEY_IN_W-1:0]    in_key,
  input  logic [POS_W-1:0]       in_position,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATUS_W-1:0]    out_status,
  output logic                   out_found,
  output logic [INDEX_W-1:0]     out_index,
  output logic [COUNT_OUT_W-1:0] out_count
);

  skt_cmd_t  cmd;
  skt_stat_t stat;

  skt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  skt_datapath #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_func     (in_func),
    .in_key      (in_key),
    .in_position (in_position),
    .cmd         (cmd),
    .stat        (stat),
    .out_status  (out_status),
    .out_found   (out_found),
    .out_index   (out_index),
    .out_count   (out_count)
  );

endmodule
